@@ rtl/block_distribution_leader_map_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the block distribution leader map core
// Shared concurrent assertion forms, clocked on a rising edge, reset disabled.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DISTRIBUTION_LEADER_MAP_CORE_MACROS_SVH
`define BLOCK_DISTRIBUTION_LEADER_MAP_CORE_MACROS_SVH

// Same-cycle implication
`define BDLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BDLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bdlm_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlm_pkg
// Widths, register indexes, sequencer states and divider control types.
// ----------------------------------------------------------------------------
package bdlm_pkg;

	// default rank ceiling
	localparam int MAX_RANKS_DEF = 64;

	// field widths
	localparam int COUNT_W    = 7;
	localparam int RANK_W     = 6;
	localparam int CFG_ADDR_W = 2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_CLIENT_COUNT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SERVER_COUNT = 2'd1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_MUL,
		ST_DIV2,
		ST_EMIT
	} state_t;

	// divider request
	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] dividend;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	// divider response
	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] quotient;
		logic [COUNT_W-1:0] remainder;
	} div_rsp_t;

endpackage

@@ rtl/bdlm_if.sv @@
// ----------------------------------------------------------------------------
// bdlm channel interfaces
// Valid/ready channels for the rank request, the server result and config.
// ----------------------------------------------------------------------------
interface bdlm_in_if;
	logic                         valid;
	logic                         ready;
	logic [bdlm_pkg::RANK_W-1:0]  client_rank;

	modport source (output valid, output client_rank, input ready);
	modport sink   (input valid, input client_rank, output ready);
endinterface

interface bdlm_out_if;
	logic                         valid;
	logic                         ready;
	logic [bdlm_pkg::RANK_W-1:0]  server_rank;
	logic                         leader;
	logic                         last;

	modport source (output valid, output server_rank, output leader, output last, input ready);
	modport sink   (input valid, input server_rank, input leader, input last, output ready);
endinterface

interface bdlm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bdlm_pkg::CFG_ADDR_W-1:0]  addr;
	logic [bdlm_pkg::COUNT_W-1:0]     data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/block_distribution_leader_map_core.sv @@
// The first result word follows one division when clients are fewer than servers,
// two divisions otherwise; the shared 7-step divider performs both divisions.
// A new rank is taken only once the last word of the previous block has left;
// the words of one block leave at one per cycle while rsp.ready is held high.
// Reset: asynchronous, active low; both counts return to 1, sequencer to idle.
// ----------------------------------------------------------------------------
// block_distribution_leader_map_core
// Maps a client rank onto its linked server ranks under a block distribution.
// ----------------------------------------------------------------------------
`include "block_distribution_leader_map_core_macros.svh"

module block_distribution_leader_map_core #(
	parameter int MAX_RANKS = bdlm_pkg::MAX_RANKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bdlm_cfg_if.sink    cfg,
	bdlm_in_if.sink     req,
	bdlm_out_if.source  rsp
);

	localparam int CW = bdlm_pkg::COUNT_W;
	localparam int RW = bdlm_pkg::RANK_W;
	localparam int MW = 2 * CW;
	localparam logic [CW-1:0] SAT = CW'(MAX_RANKS);

	bdlm_pkg::state_t   state_q, state_d;
	bdlm_pkg::div_req_t div_req;
	bdlm_pkg::div_rsp_t div_rsp;

	logic [CW-1:0] nc_q, ns_q;
	logic [RW-1:0] rank_q;
	logic          small_q;
	logic          seg_q;
	logic [CW-1:0] per_q;
	logic [CW-1:0] remd_q;
	logic [RW-1:0] cur_q;
	logic [CW-1:0] left_q;
	logic          lead_q;

	logic          in_fire, out_fire, rank_ok, small_in;
	logic [CW-1:0] mul_a, mul_b;
	logic [MW-1:0] prod;
	logic          rank_lt_rem, in_big;
	logic [RW-1:0] blk_start, grp_r;
	logic [CW-1:0] blk_count;

	function automatic logic [CW-1:0] sat_count(input logic [CW-1:0] v);
		return (v > SAT) ? SAT : v;
	endfunction

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= CW'(1);
			ns_q <= CW'(1);
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				bdlm_pkg::CFG_CLIENT_COUNT: nc_q <= sat_count(cfg.data);
				bdlm_pkg::CFG_SERVER_COUNT: ns_q <= sat_count(cfg.data);
				default: ;
			endcase
		end
	end

	// handshakes and request checks
	assign in_fire  = req.valid && req.ready;
	assign out_fire = rsp.valid && rsp.ready;
	assign rank_ok  = (nc_q != '0) && (ns_q != '0) && ({1'b0, req.client_rank} < nc_q);
	assign small_in = nc_q < ns_q;

	// shared multiplier: per*rank for a block, (per+1)*rem for groups
	assign mul_a = small_q ? per_q : per_q + CW'(1);
	assign mul_b = small_q ? {1'b0, rank_q} : remd_q;
	assign prod  = MW'(mul_a) * MW'(mul_b);

	// block case: first server and block length
	assign rank_lt_rem = {1'b0, rank_q} < remd_q;
	assign blk_start   = prod[RW-1:0] + (rank_lt_rem ? rank_q : remd_q[RW-1:0]);
	assign blk_count   = per_q + CW'(rank_lt_rem);

	// grouped case: pick the large or the normal groups
	assign in_big = MW'(rank_q) < prod;
	assign grp_r  = rank_q - prod[RW-1:0];

	bdlm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdlm_pkg::ST_IDLE: if (in_fire && rank_ok) state_d = bdlm_pkg::ST_DIV1;
			bdlm_pkg::ST_DIV1: if (div_rsp.done) state_d = bdlm_pkg::ST_MUL;
			bdlm_pkg::ST_MUL:  state_d = small_q ? bdlm_pkg::ST_EMIT : bdlm_pkg::ST_DIV2;
			bdlm_pkg::ST_DIV2: if (div_rsp.done) state_d = bdlm_pkg::ST_EMIT;
			bdlm_pkg::ST_EMIT: if (out_fire && left_q == CW'(1)) state_d = bdlm_pkg::ST_IDLE;
			default:           state_d = bdlm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready        = 1'b0;
		rsp.valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			bdlm_pkg::ST_IDLE: begin
				req.ready        = 1'b1;
				div_req.start    = in_fire && rank_ok;
				div_req.dividend = small_in ? ns_q : nc_q;
				div_req.divisor  = small_in ? nc_q : ns_q;
			end
			bdlm_pkg::ST_MUL: begin
				div_req.start    = !small_q;
				div_req.dividend = in_big ? {1'b0, rank_q} : {1'b0, grp_r};
				div_req.divisor  = in_big ? mul_a : per_q;
			end
			bdlm_pkg::ST_EMIT: rsp.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			bdlm_pkg::ST_IDLE: begin
				if (in_fire) begin
					rank_q  <= req.client_rank;
					small_q <= small_in;
				end
			end
			bdlm_pkg::ST_DIV1: begin
				if (div_rsp.done) begin
					per_q  <= div_rsp.quotient;
					remd_q <= div_rsp.remainder;
				end
			end
			bdlm_pkg::ST_MUL: begin
				if (small_q) begin
					cur_q  <= blk_start;
					left_q <= blk_count;
					lead_q <= 1'b1;
				end else begin
					seg_q  <= !in_big;
					left_q <= CW'(1);
				end
			end
			bdlm_pkg::ST_DIV2: begin
				if (div_rsp.done) begin
					cur_q  <= seg_q ? remd_q[RW-1:0] + div_rsp.quotient[RW-1:0]
					                : div_rsp.quotient[RW-1:0];
					lead_q <= div_rsp.remainder == '0;
				end
			end
			bdlm_pkg::ST_EMIT: begin
				if (out_fire) begin
					cur_q  <= cur_q + RW'(1);
					left_q <= left_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	// result word
	assign rsp.server_rank = cur_q;
	assign rsp.leader      = lead_q;
	assign rsp.last        = left_q == CW'(1);

	// checks
	`BDLM_ASSERT_NOW(a_no_take_while_out, clk, arst_n, rsp.valid, !req.ready, "rank taken while a word waits")
	`BDLM_ASSERT_NOW(a_srv_in_range, clk, arst_n, rsp.valid, {1'b0, rsp.server_rank} < ns_q, "server rank beyond server count")
	`BDLM_ASSERT_NOW(a_div_done_waited, clk, arst_n, div_rsp.done, state_q == bdlm_pkg::ST_DIV1 || state_q == bdlm_pkg::ST_DIV2, "divider finished while not awaited")
	`BDLM_ASSERT_NEXT(a_last_to_idle, clk, arst_n, out_fire && rsp.last, req.ready, "not idle after last word")

endmodule

@@ rtl/bdlm_div.sv @@
// ----------------------------------------------------------------------------
// bdlm_div
// Restoring divider, one quotient bit a cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module bdlm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bdlm_pkg::div_req_t req,
	output bdlm_pkg::div_rsp_t rsp
);

	localparam int W  = bdlm_pkg::COUNT_W;
	localparam int CW = $clog2(W);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shift;
	logic [W:0]    diff;
	logic          fits;

	// shift in the next dividend bit and trial-subtract
	assign shift = {rem_q, quo_q[W-1]};
	assign diff  = shift - {1'b0, div_q};
	assign fits  = shift >= {1'b0, div_q};

	// control: count the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: load, then one step a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[W-1:0] : shift[W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
